// ===== rtl/core/dxbd_pkg.sv =====
// Shared types, constants and color helper functions of the block pixel decoder.
`timescale 1ns / 1ps

package dxbd_pkg;

    localparam int COLOR_W        = 16;
    localparam int INDEX_W        = 32;
    localparam int COORD_W        = 14;
    localparam int CHAN_W         = 8;
    localparam int SUM_W          = 10;
    localparam int PROD_W         = 20;
    localparam int PAL_SIZE       = 4;
    localparam int PIX_CNT_W      = 4;
    localparam int EDGE_W         = 2;
    localparam int DXBD_QUEUE_DEPTH = 2;

    localparam logic [PIX_CNT_W-1:0] PIX_LAST     = 4'd15;
    localparam logic [SUM_W-1:0]     RECIP_THIRD  = 10'd683;
    localparam int                   RECIP_SHIFT  = 11;

    typedef struct packed {
        logic [PAL_SIZE-1:0][CHAN_W-1:0] red;
        logic [PAL_SIZE-1:0][CHAN_W-1:0] green;
        logic [PAL_SIZE-1:0][CHAN_W-1:0] blue;
        logic [INDEX_W-1:0]              index_bits;
        logic [COORD_W-1:0]              block_x;
        logic [COORD_W-1:0]              block_y;
    } blk_t;

    function automatic logic [CHAN_W-1:0] widen5(input logic [4:0] v);
        widen5 = {v, v[4:2]};
    endfunction

    function automatic logic [CHAN_W-1:0] widen6(input logic [5:0] v);
        widen6 = {v, v[5:4]};
    endfunction

    // Exact floor(x / 3) for x below 768, as a multiply by a scaled reciprocal.
    function automatic logic [CHAN_W-1:0] div3(input logic [SUM_W-1:0] x);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(x) * PROD_W'(RECIP_THIRD);
        div3 = prod[RECIP_SHIFT +: CHAN_W];
    endfunction

endpackage

// ===== rtl/core/dxbd_front.sv =====
// Front stage: accepts a block, unpacks the endpoints and builds the four-entry palette.
`timescale 1ns / 1ps

module dxbd_front
    import dxbd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [COLOR_W-1:0] s_color_a,
    input  logic [COLOR_W-1:0] s_color_b,
    input  logic [INDEX_W-1:0] s_index_bits,
    input  logic [COORD_W-1:0] s_block_x,
    input  logic [COORD_W-1:0] s_block_y,
    output logic               q_valid,
    input  logic               q_ready,
    output blk_t               q_blk
);

    logic [2:0][CHAN_W-1:0] chan_a;
    logic [2:0][CHAN_W-1:0] chan_b;
    blk_t                   blk_next;
    blk_t                   blk_reg;
    logic                   valid_reg;

    always_comb begin
        chan_a[0] = widen5(s_color_a[4:0]);
        chan_a[1] = widen6(s_color_a[10:5]);
        chan_a[2] = widen5(s_color_a[15:11]);
        chan_b[0] = widen5(s_color_b[4:0]);
        chan_b[1] = widen6(s_color_b[10:5]);
        chan_b[2] = widen5(s_color_b[15:11]);

        blk_next.red[0]   = chan_a[0];
        blk_next.red[1]   = chan_b[0];
        blk_next.red[2]   = div3({1'b0, chan_a[0], 1'b0} + {2'b00, chan_b[0]});
        blk_next.red[3]   = div3({2'b00, chan_a[0]} + {1'b0, chan_b[0], 1'b0});
        blk_next.green[0] = chan_a[1];
        blk_next.green[1] = chan_b[1];
        blk_next.green[2] = div3({1'b0, chan_a[1], 1'b0} + {2'b00, chan_b[1]});
        blk_next.green[3] = div3({2'b00, chan_a[1]} + {1'b0, chan_b[1], 1'b0});
        blk_next.blue[0]  = chan_a[2];
        blk_next.blue[1]  = chan_b[2];
        blk_next.blue[2]  = div3({1'b0, chan_a[2], 1'b0} + {2'b00, chan_b[2]});
        blk_next.blue[3]  = div3({2'b00, chan_a[2]} + {1'b0, chan_b[2], 1'b0});
        blk_next.index_bits = s_index_bits;
        blk_next.block_x    = s_block_x;
        blk_next.block_y    = s_block_y;
    end

    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_blk   = blk_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            blk_reg <= blk_next;
        end
    end

endmodule

// ===== rtl/core/dxbd_queue.sv =====
// Short queue of decoded blocks between the front and back stages.
`timescale 1ns / 1ps

module dxbd_queue
    import dxbd_pkg::*;
#(
    parameter int DEPTH = DXBD_QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  blk_t wr_blk,
    output logic rd_valid,
    input  logic rd_pop,
    output blk_t rd_blk
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    blk_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign wr_ready = count_reg != CNT_W'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_blk   = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_blk;
        end
    end

endmodule

// ===== rtl/core/dxbd_back.sv =====
// Back stage: walks the sixteen pixels of the head block into the output register.
`timescale 1ns / 1ps

module dxbd_back
    import dxbd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_pop,
    input  blk_t               q_blk,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COORD_W-1:0] m_pixel_x,
    output logic [COORD_W-1:0] m_pixel_y,
    output logic [CHAN_W-1:0]  m_red,
    output logic [CHAN_W-1:0]  m_green,
    output logic [CHAN_W-1:0]  m_blue,
    output logic               m_last
);

    logic [PIX_CNT_W-1:0] count_reg;
    logic                 m_valid_reg;
    logic [COORD_W-1:0]   pixel_x_reg;
    logic [COORD_W-1:0]   pixel_y_reg;
    logic [CHAN_W-1:0]    red_reg;
    logic [CHAN_W-1:0]    green_reg;
    logic [CHAN_W-1:0]    blue_reg;
    logic                 last_reg;
    logic                 load;
    logic [EDGE_W-1:0]    sel;
    logic [EDGE_W-1:0]    col;
    logic [EDGE_W-1:0]    row;

    assign load  = q_valid && (!m_valid_reg || m_ready);
    assign q_pop = load && (count_reg == PIX_LAST);
    assign sel   = q_blk.index_bits[{count_reg, 1'b0} +: EDGE_W];
    assign col   = count_reg[EDGE_W-1:0];
    // Rows are emitted bottom-up, so the row offset is the inverted row count.
    assign row   = ~count_reg[PIX_CNT_W-1:EDGE_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                count_reg <= count_reg + 1'b1;
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pixel_x_reg <= q_blk.block_x + {{(COORD_W-EDGE_W){1'b0}}, col};
            pixel_y_reg <= q_blk.block_y + {{(COORD_W-EDGE_W){1'b0}}, row};
            red_reg     <= q_blk.red[sel];
            green_reg   <= q_blk.green[sel];
            blue_reg    <= q_blk.blue[sel];
            last_reg    <= count_reg == PIX_LAST;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_pixel_x = pixel_x_reg;
    assign m_pixel_y = pixel_y_reg;
    assign m_red     = red_reg;
    assign m_green   = green_reg;
    assign m_blue    = blue_reg;
    assign m_last    = last_reg;

endmodule

// ===== rtl/core/dxt1_block_pixel_decoder_core.sv =====
// Top level of the block pixel decoder: front stage, block queue and pixel back stage.
//
//  Channel | Direction | Handshake          | Payload
//  s_      | input     | s_valid / s_ready  | color_a, color_b, index_bits, block_x, block_y
//  m_      | output    | m_valid / m_ready  | pixel_x, pixel_y, red, green, blue, last
//
// Each block produces sixteen pixels, one per cycle while m_ready does not stall the output;
// the back stage's single output register sets that rate. A block passes the front register,
// the queue memory and the back output register before its first pixel appears.
// The front stage and queue take further blocks while the back stage is busy or stalled.
// Reset is synchronous and active low, and empties all stages.
`timescale 1ns / 1ps

module dxt1_block_pixel_decoder_core
    import dxbd_pkg::*;
#(
    parameter int QUEUE_DEPTH = DXBD_QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [COLOR_W-1:0] s_color_a,
    input  logic [COLOR_W-1:0] s_color_b,
    input  logic [INDEX_W-1:0] s_index_bits,
    input  logic [COORD_W-1:0] s_block_x,
    input  logic [COORD_W-1:0] s_block_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COORD_W-1:0] m_pixel_x,
    output logic [COORD_W-1:0] m_pixel_y,
    output logic [CHAN_W-1:0]  m_red,
    output logic [CHAN_W-1:0]  m_green,
    output logic [CHAN_W-1:0]  m_blue,
    output logic               m_last
);

    logic fq_valid;
    logic fq_ready;
    blk_t fq_blk;
    logic qb_valid;
    logic qb_pop;
    blk_t qb_blk;

    dxbd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_color_a    (s_color_a),
        .s_color_b    (s_color_b),
        .s_index_bits (s_index_bits),
        .s_block_x    (s_block_x),
        .s_block_y    (s_block_y),
        .q_valid      (fq_valid),
        .q_ready      (fq_ready),
        .q_blk        (fq_blk)
    );

    dxbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_blk   (fq_blk),
        .rd_valid (qb_valid),
        .rd_pop   (qb_pop),
        .rd_blk   (qb_blk)
    );

    dxbd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (qb_valid),
        .q_pop     (qb_pop),
        .q_blk     (qb_blk),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_pixel_x (m_pixel_x),
        .m_pixel_y (m_pixel_y),
        .m_red     (m_red),
        .m_green   (m_green),
        .m_blue    (m_blue),
        .m_last    (m_last)
    );

endmodule

// ===== rtl/core/dxbd_checker.sv =====
// Port-level assertions for the block pixel decoder, bound to its top level.
`timescale 1ns / 1ps

module dxbd_checker
    import dxbd_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [COORD_W-1:0] m_pixel_x,
    input logic [COORD_W-1:0] m_pixel_y,
    input logic               m_last
);

    // A stalled result keeps its coordinates and end-of-block flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_x) && $stable(m_pixel_y)
            && $stable(m_last))
        else $error("stalled result changed");

    // Reset leaves no result pending and the input side open.
    assert property (@(posedge aclk) $past(!aresetn) |-> !m_valid && s_ready)
        else $error("state not cleared by reset");

    // Within a block the pixels follow each other without a gap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("gap inside a block");

    // Within a block the row stays or moves down by one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=>
            m_pixel_y == $past(m_pixel_y) || m_pixel_y == $past(m_pixel_y) - 14'd1)
        else $error("row order broken inside a block");

endmodule

bind dxt1_block_pixel_decoder_core dxbd_checker u_dxbd_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_pixel_x (m_pixel_x),
    .m_pixel_y (m_pixel_y),
    .m_last    (m_last)
);

// ===== tb/dxt1_pixel_checker.sv =====
// Checker that predicts the sixteen pixels of every accepted block and compares them.
`timescale 1ns / 1ps

module dxt1_pixel_checker
    import dxbd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [COLOR_W-1:0] s_color_a,
    input  logic [COLOR_W-1:0] s_color_b,
    input  logic [INDEX_W-1:0] s_index_bits,
    input  logic [COORD_W-1:0] s_block_x,
    input  logic [COORD_W-1:0] s_block_y,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [COORD_W-1:0] m_pixel_x,
    input  logic [COORD_W-1:0] m_pixel_y,
    input  logic [CHAN_W-1:0]  m_red,
    input  logic [CHAN_W-1:0]  m_green,
    input  logic [CHAN_W-1:0]  m_blue,
    input  logic               m_last,
    output int                 fail_count,
    output int                 pixels_pending,
    output int                 blocks_seen,
    output int                 pixels_seen
);

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic               last;
    } pixel_t;

    pixel_t expected_pixels[$];
    int     mismatches    = 0;
    int     pending_count = 0;
    int     block_count   = 0;
    int     pixel_count   = 0;

    assign fail_count     = mismatches;
    assign pixels_pending = pending_count;
    assign blocks_seen    = block_count;
    assign pixels_seen    = pixel_count;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Builds the four-entry palette and queues the pixels in output order.
    function automatic void predict_block(
        input logic [COLOR_W-1:0] ca,
        input logic [COLOR_W-1:0] cb,
        input logic [INDEX_W-1:0] idx,
        input logic [COORD_W-1:0] bx,
        input logic [COORD_W-1:0] by
    );
        logic [CHAN_W-1:0] palette [4][3];
        logic [1:0]        code;
        pixel_t            px;
        int                row;
        int                col;
        int                ch;
        int                n;

        palette[0][0] = {ca[4:0], ca[4:2]};
        palette[0][1] = {ca[10:5], ca[10:9]};
        palette[0][2] = {ca[15:11], ca[15:13]};
        palette[1][0] = {cb[4:0], cb[4:2]};
        palette[1][1] = {cb[10:5], cb[10:9]};
        palette[1][2] = {cb[15:11], cb[15:13]};
        for (ch = 0; ch < 3; ch++) begin
            palette[2][ch] = CHAN_W'((2 * int'(palette[0][ch]) + int'(palette[1][ch])) / 3);
            palette[3][ch] = CHAN_W'((int'(palette[0][ch]) + 2 * int'(palette[1][ch])) / 3);
        end
        n = 0;
        for (row = 3; row >= 0; row--) begin
            for (col = 0; col < 4; col++) begin
                code     = idx[2*n +: 2];
                px.x     = bx + COORD_W'(col);
                px.y     = by + COORD_W'(row);
                px.red   = palette[code][0];
                px.green = palette[code][1];
                px.blue  = palette[code][2];
                px.last  = (n == 15);
                expected_pixels.push_back(px);
                n++;
            end
        end
    endfunction

    always @(posedge aclk) begin
        pixel_t want;
        if (!aresetn) begin
            expected_pixels.delete();
        end else begin
            if (m_valid && m_ready) begin
                pixel_count++;
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("pixel %0d arrived with no block pending",
                                              pixel_count));
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_pixel_x !== want.x)
                        report_mismatch($sformatf("pixel %0d: pixel_x %0d, expected %0d",
                                                  pixel_count, m_pixel_x, want.x));
                    if (m_pixel_y !== want.y)
                        report_mismatch($sformatf("pixel %0d: pixel_y %0d, expected %0d",
                                                  pixel_count, m_pixel_y, want.y));
                    if (m_red !== want.red)
                        report_mismatch($sformatf("pixel %0d: red %0d, expected %0d",
                                                  pixel_count, m_red, want.red));
                    if (m_green !== want.green)
                        report_mismatch($sformatf("pixel %0d: green %0d, expected %0d",
                                                  pixel_count, m_green, want.green));
                    if (m_blue !== want.blue)
                        report_mismatch($sformatf("pixel %0d: blue %0d, expected %0d",
                                                  pixel_count, m_blue, want.blue));
                    if (m_last !== want.last)
                        report_mismatch($sformatf("pixel %0d: last %0b, expected %0b",
                                                  pixel_count, m_last, want.last));
                end
            end
            if (s_valid && s_ready) begin
                block_count++;
                predict_block(s_color_a, s_color_b, s_index_bits, s_block_x, s_block_y);
            end
        end
        pending_count <= expected_pixels.size();
    end

endmodule

// ===== tb/tb_dxt1_block_pixel_decoder_core.sv =====
// Top of the block pixel decoder testbench: clock, reset, block stimulus and verdict.
`timescale 1ns / 1ps

module tb_dxt1_block_pixel_decoder_core;
    import dxbd_pkg::*;

    localparam int RANDOM_BLOCKS = 358;
    localparam int IDLE_LIMIT    = 1000;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [COLOR_W-1:0] s_color_a;
    logic [COLOR_W-1:0] s_color_b;
    logic [INDEX_W-1:0] s_index_bits;
    logic [COORD_W-1:0] s_block_x;
    logic [COORD_W-1:0] s_block_y;
    logic               m_valid;
    logic               m_ready;
    logic [COORD_W-1:0] m_pixel_x;
    logic [COORD_W-1:0] m_pixel_y;
    logic [CHAN_W-1:0]  m_red;
    logic [CHAN_W-1:0]  m_green;
    logic [CHAN_W-1:0]  m_blue;
    logic               m_last;

    int fail_count;
    int pixels_pending;
    int blocks_seen;
    int pixels_seen;
    int idle_cycles = 0;
    bit no_stall    = 1'b0;

    dxt1_block_pixel_decoder_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_color_a    (s_color_a),
        .s_color_b    (s_color_b),
        .s_index_bits (s_index_bits),
        .s_block_x    (s_block_x),
        .s_block_y    (s_block_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_x    (m_pixel_x),
        .m_pixel_y    (m_pixel_y),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .m_last       (m_last)
    );

    dxt1_pixel_checker pixel_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_color_a      (s_color_a),
        .s_color_b      (s_color_b),
        .s_index_bits   (s_index_bits),
        .s_block_x      (s_block_x),
        .s_block_y      (s_block_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue),
        .m_last         (m_last),
        .fail_count     (fail_count),
        .pixels_pending (pixels_pending),
        .blocks_seen    (blocks_seen),
        .pixels_seen    (pixels_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles.", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int gap;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            gap = no_stall ? 0 : $urandom_range(0, 7);
            repeat (gap) begin
                m_ready <= 1'b0;
                @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    task automatic send_block(
        input logic [COLOR_W-1:0] ca,
        input logic [COLOR_W-1:0] cb,
        input logic [INDEX_W-1:0] idx,
        input logic [COORD_W-1:0] bx,
        input logic [COORD_W-1:0] by
    );
        int gap;
        gap = no_stall ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_color_a    <= ca;
        s_color_b    <= cb;
        s_index_bits <= idx;
        s_block_x    <= bx;
        s_block_y    <= by;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pixels_pending != 0) @(posedge aclk);
    endtask

    function automatic logic [COORD_W-1:0] pick_origin();
        case ($urandom_range(0, 3))
            0:       pick_origin = COORD_W'($urandom_range(16376, 16383));
            1:       pick_origin = {12'($urandom_range(0, 4095)), 2'b00};
            default: pick_origin = COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [COLOR_W-1:0] pick_color();
        case ($urandom_range(0, 7))
            0:       pick_color = '0;
            1:       pick_color = '1;
            default: pick_color = COLOR_W'($urandom);
        endcase
    endfunction

    initial begin
        logic [INDEX_W-1:0] idx;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_color_a    <= '0;
        s_color_b    <= '0;
        s_index_bits <= '0;
        s_block_x    <= '0;
        s_block_y    <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_block(16'h0000, 16'h0000, 32'h0000_0000, 14'd0, 14'd0);
        send_block(16'hffff, 16'hffff, 32'hffff_ffff, 14'd16383, 14'd16383);
        send_block(16'hffff, 16'h0000, 32'he4e4_e4e4, 14'd16380, 14'd16380);
        send_block(16'h0000, 16'hffff, 32'h1b1b_1b1b, 14'd16381, 14'd5);
        send_block(16'h001f, 16'h0000, 32'haaaa_aaaa, 14'd5, 14'd16382);
        send_block(16'h07e0, 16'h0020, 32'h5555_5555, 14'd8191, 14'd8192);
        send_block(16'hf800, 16'h0800, 32'hffff_ffff, 14'd8192, 14'd8191);
        send_block(16'h1234, 16'h1234, 32'h1234_5678, 14'd4, 14'd16379);
        send_block(16'h0821, 16'hf7de, 32'h0000_ffff, 14'd16382, 14'd0);
        send_block(16'hf7de, 16'h0821, 32'hffff_0000, 14'd0, 14'd16381);
        send_block(16'h001f, 16'hf800, 32'hb1b1_4e4e, 14'd12, 14'd16383);
        send_block(16'h07e0, 16'hffe0, 32'h8765_4321, 14'd16383, 14'd7);
        wait_for_drain();

        for (int i = 0; i < RANDOM_BLOCKS; i++) begin
            no_stall = (i >= 100 && i < 140);
            if (i == 200)
                wait_for_drain();
            if ($urandom_range(0, 5) == 0)
                idx = {16{2'($urandom_range(0, 3))}};
            else
                idx = $urandom;
            send_block(pick_color(), pick_color(), idx, pick_origin(), pick_origin());
        end
        no_stall = 1'b0;
        wait_for_drain();
        repeat (24) @(posedge aclk);

        $display("Decoded %0d blocks into %0d checked pixels, %0d mismatches, %0d left over.",
                 blocks_seen, pixels_seen, fail_count, pixels_pending);
        $display("Covered endpoint extremes, all index codes, coordinate wrap and stalls.");
        if (fail_count == 0 && pixels_pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
